>>> rtl/core/popip_pkg.sv
// Shared constants, codes and controller/datapath command types for the polygon block.
package popip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int DEPTH        = 2 * MAX_VERTICES;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int LAT_W        = 28;
  localparam int LON_W        = 29;
  localparam int VTX_W        = LAT_W + LON_W;
  localparam int DLAT_W       = LAT_W + 1;
  localparam int DLON_W       = LON_W + 1;
  localparam int PROD_W       = DLAT_W + DLON_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2,
    OP_OVL    = 2'd3
  } op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              edge_rd;
    logic              load_pt;
    logic              cap_pt;
    logic              clr_inside;
    logic              clr_acc;
    logic              acc_a;
    logic              acc_b;
    logic              res_load;
    op_t               res_op;
    logic              res_status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;
  } stat_t;

endpackage

>>> rtl/core/popip_in_if.sv
// Input channel: operation word with valid/ready handshake.
interface popip_in_if;
  import popip_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic                    poly_sel;
  logic signed [LAT_W-1:0] lat;
  logic signed [LON_W-1:0] lon;

  modport source (output valid, operation, poly_sel, lat, lon, input ready);
  modport sink   (input valid, operation, poly_sel, lat, lon, output ready);
endinterface

>>> rtl/core/popip_out_if.sv
// Output channel: result word with valid/ready handshake.
interface popip_out_if;
  logic valid;
  logic ready;
  logic status;
  logic point_inside;
  logic a_in_b;
  logic b_in_a;
  logic overlap;

  modport source (output valid, status, point_inside, a_in_b, b_in_a, overlap, input ready);
  modport sink   (input valid, status, point_inside, a_in_b, b_in_a, overlap, output ready);
endinterface

>>> rtl/core/popip_dp.sv
// Datapath: vertex memory, edge crossing pipeline, flags and result register.
module popip_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  popip_pkg::cmd_t                   cmd,
  output popip_pkg::stat_t                  stat,
  input  logic signed [popip_pkg::LAT_W-1:0] in_lat,
  input  logic signed [popip_pkg::LON_W-1:0] in_lon,
  output logic                              status,
  output logic                              point_inside,
  output logic                              a_in_b,
  output logic                              b_in_a,
  output logic                              overlap
);
  import popip_pkg::*;

  logic [VTX_W-1:0] mem [DEPTH];
  logic [VTX_W-1:0] rdata;

  logic rd_v1, edge_v1, load_v1;
  logic signed [LAT_W-1:0] pt_lat, prev_lat, cur_lat;
  logic signed [LON_W-1:0] pt_lon, prev_lon, cur_lon;

  logic v2, e2;
  logic signed [DLAT_W-1:0] d2, c2;
  logic signed [DLON_W-1:0] a2, b2;
  logic cond;

  logic v3, e3, dpos3;
  logic signed [PROD_W-1:0] lhs3, rhs3;
  logic crossed;

  logic parity, a_acc, b_acc;

  // Write appended vertices, read one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= {in_lat, in_lon};
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.addr];
    end
  end

  assign cur_lat = rdata[VTX_W-1:LON_W];
  assign cur_lon = rdata[LON_W-1:0];

  assign cond = (cur_lat > pt_lat) != (prev_lat > pt_lat);

  // Stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v1   <= 1'b0;
      edge_v1 <= 1'b0;
      load_v1 <= 1'b0;
      v2      <= 1'b0;
      e2      <= 1'b0;
      v3      <= 1'b0;
      e3      <= 1'b0;
    end else begin
      rd_v1   <= cmd.rd_en;
      edge_v1 <= cmd.rd_en && cmd.edge_rd;
      load_v1 <= cmd.rd_en && cmd.load_pt;
      v2      <= edge_v1;
      e2      <= edge_v1 && cond;
      v3      <= v2;
      e3      <= e2;
    end
  end

  // Capture test point, track previous vertex, form differences, multiply
  always_ff @(posedge clk) begin
    if (cmd.cap_pt) begin
      pt_lat <= in_lat;
      pt_lon <= in_lon;
    end else if (load_v1) begin
      pt_lat <= cur_lat;
      pt_lon <= cur_lon;
    end
    if (rd_v1 && !load_v1) begin
      prev_lat <= cur_lat;
      prev_lon <= cur_lon;
    end
    d2    <= DLAT_W'(prev_lat) - DLAT_W'(cur_lat);
    c2    <= DLAT_W'(pt_lat) - DLAT_W'(cur_lat);
    a2    <= DLON_W'(pt_lon) - DLON_W'(cur_lon);
    b2    <= DLON_W'(prev_lon) - DLON_W'(cur_lon);
    lhs3  <= a2 * d2;
    rhs3  <= b2 * c2;
    dpos3 <= d2 > 0;
  end

  assign crossed = dpos3 ? (lhs3 < rhs3) : (lhs3 > rhs3);

  // Toggle parity, accumulate overlap flags, load result
  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
      a_acc  <= 1'b0;
      b_acc  <= 1'b0;
    end else begin
      if (cmd.clr_inside) begin
        parity <= 1'b0;
      end else if (e3 && crossed) begin
        parity <= !parity;
      end
      if (cmd.clr_acc) begin
        a_acc <= 1'b0;
        b_acc <= 1'b0;
      end else begin
        if (cmd.acc_a) a_acc <= a_acc | parity;
        if (cmd.acc_b) b_acc <= b_acc | parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status       <= cmd.res_status;
      point_inside <= (cmd.res_op == OP_TEST) && parity;
      a_in_b       <= (cmd.res_op == OP_OVL) && a_acc;
      b_in_a       <= (cmd.res_op == OP_OVL) && b_acc;
      overlap      <= (cmd.res_op == OP_OVL) && (a_acc || b_acc);
    end
  end

  assign stat.busy = rd_v1 || v2 || v3;

endmodule

>>> rtl/core/popip_ctrl.sv
// Controller: vertex counts, walk sequencing and handshakes.
module popip_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic             in_sel,
  output logic             out_valid,
  input  logic             out_ready,
  output popip_pkg::cmd_t  cmd,
  input  popip_pkg::stat_t stat
);
  import popip_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_OV_NEXT, S_WALK, S_DRAIN, S_DONE} state_t;

  state_t           state;
  op_t              op;
  logic             status;
  logic             phase;
  logic             walk_p;
  logic [CNT_W-1:0] cnt [2];
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] widx;
  logic [CNT_W-1:0] walk_n;
  logic [CNT_W-1:0] idx;
  logic             accept;
  op_t              in_code;
  logic             out_free;
  logic             ov_skip;

  assign in_code  = op_t'(in_op);
  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign walk_n   = cnt[walk_p];
  assign ov_skip  = (k == cnt[phase]) || (cnt[!phase] < CNT_W'(3));

  // Address select per state
  always_comb begin
    unique case (state)
      S_IDLE:    idx = cnt[in_sel];
      S_OV_NEXT: idx = k;
      S_WALK:    idx = (widx == '0) ? walk_n - CNT_W'(1) : widx - CNT_W'(1);
      default:   idx = '0;
    endcase
  end

  // Decode commands
  always_comb begin
    cmd            = '0;
    cmd.res_op     = op;
    cmd.res_status = status;
    unique case (state)
      S_IDLE: begin
        cmd.addr       = ADDR_W'(idx) + (in_sel ? ADDR_W'(MAX_VERTICES) : '0);
        cmd.wr_en      = accept && in_code == OP_APPEND && cnt[in_sel] < CNT_W'(MAX_VERTICES);
        cmd.cap_pt     = accept && in_code == OP_TEST;
        cmd.clr_inside = accept && in_code == OP_TEST;
        cmd.clr_acc    = accept && in_code == OP_OVL;
      end
      S_OV_NEXT: begin
        cmd.addr       = ADDR_W'(idx) + (phase ? ADDR_W'(MAX_VERTICES) : '0);
        cmd.rd_en      = !ov_skip;
        cmd.load_pt    = !ov_skip;
        cmd.clr_inside = !ov_skip;
      end
      S_WALK: begin
        cmd.addr    = ADDR_W'(idx) + (walk_p ? ADDR_W'(MAX_VERTICES) : '0);
        cmd.rd_en   = 1'b1;
        cmd.edge_rd = widx != '0;
      end
      S_DRAIN: begin
        cmd.acc_a = !stat.busy && op == OP_OVL && !phase;
        cmd.acc_b = !stat.busy && op == OP_OVL && phase;
      end
      S_DONE: begin
        cmd.res_load = out_free;
      end
      default: ;
    endcase
  end

  // State, counts and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      out_valid <= 1'b0;
      op        <= OP_CLEAR;
      status    <= 1'b0;
      phase     <= 1'b0;
      walk_p    <= 1'b0;
      k         <= '0;
      widx      <= '0;
    end else begin
      // Raise valid on a loaded result, drop it once the word is taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= in_code;
            status <= 1'b0;
            unique case (in_code)
              OP_CLEAR: begin
                cnt[in_sel] <= '0;
                state       <= S_DONE;
              end
              OP_APPEND: begin
                if (cnt[in_sel] < CNT_W'(MAX_VERTICES)) begin
                  cnt[in_sel] <= cnt[in_sel] + CNT_W'(1);
                end else begin
                  status <= 1'b1;
                end
                state <= S_DONE;
              end
              OP_TEST: begin
                walk_p <= in_sel;
                widx   <= '0;
                state  <= (cnt[in_sel] < CNT_W'(3)) ? S_DONE : S_WALK;
              end
              default: begin
                phase <= 1'b0;
                k     <= '0;
                state <= S_OV_NEXT;
              end
            endcase
          end
        end
        S_OV_NEXT: begin
          if (ov_skip) begin
            if (phase) begin
              state <= S_DONE;
            end else begin
              phase <= 1'b1;
              k     <= '0;
            end
          end else begin
            walk_p <= !phase;
            widx   <= '0;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (widx == walk_n) begin
            state <= S_DRAIN;
          end else begin
            widx <= widx + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (!stat.busy) begin
            if (op == OP_OVL) begin
              k     <= k + CNT_W'(1);
              state <= S_OV_NEXT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt0_max: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= CNT_W'(MAX_VERTICES)) else $error("count of polygon 0 above capacity");
  a_cnt1_max: assert property (@(posedge clk) disable iff (rst)
    cnt[1] <= CNT_W'(MAX_VERTICES)) else $error("count of polygon 1 above capacity");
  a_wr_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |=> (status == 1'b0)) else $error("write issued on a full polygon");
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> out_free) else $error("result overwrites a pending word");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && in_code == OP_CLEAR && !in_sel) |=> cnt[0] == '0)
    else $error("clear did not empty polygon 0");

endmodule

>>> rtl/core/polygon_overlap_point_in_polygon.sv
// Top level: point-in-polygon and polygon overlap block, controller plus datapath.
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------------
//  req     | in  | operation, poly_sel, lat, lon
//  rsp     | out | status, point_inside, a_in_b, b_in_a, overlap
//
// Clear and append accept the word, then load the result word. A point test
// against a polygon of n >= 3 vertices accepts the word, reads its vertices on
// the single vertex memory port (one edge a cycle), drains the edge pipeline
// and loads the result. Overlap runs one such walk per vertex of each polygon,
// testing that vertex against the other polygon. Reset clears the counts and
// the handshake state; the vertex memory is not cleared. A new word is taken
// while the last result waits; a stalled result holds the block before its
// next result.
module polygon_overlap_point_in_polygon (
  input logic         clk,
  input logic         rst,
  popip_in_if.sink    req,
  popip_out_if.source rsp
);
  import popip_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  popip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_op     (req.operation),
    .in_sel    (req.poly_sel),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  popip_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_lat       (req.lat),
    .in_lon       (req.lon),
    .status       (rsp.status),
    .point_inside (rsp.point_inside),
    .a_in_b       (rsp.a_in_b),
    .b_in_a       (rsp.b_in_a),
    .overlap      (rsp.overlap)
  );

endmodule
